>>> rtl/core/pft_pkg.sv
// ----------------------------------------------------------------------------
// Pair frequency table package
// Shared constants, state codes and the control bundle that the table
// core broadcasts to its row of entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pft_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int FIELD_W         = 32;
  localparam int ENTRY_COUNT_W   = 16;

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_e;

  typedef struct packed {
    logic take;
    logic any_hit;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/pft_cell.sv
// ----------------------------------------------------------------------------
// Pair frequency table entry cell
// Holds one distinct pair and its saturating count. It compares the
// incoming pair, claims a new pair when it is the first free cell, and
// takes its neighbor's entry when the table shifts out during readout.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_cell #(
  parameter int CountBits = pft_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pft_pkg::cell_ctrl_t                ctrl_i,
  input  wire logic signed [pft_pkg::FIELD_W-1:0] pair_first_i,
  input  wire logic signed [pft_pkg::FIELD_W-1:0] pair_second_i,
  input  wire logic                               prev_valid_i,
  input  wire logic                               next_valid_i,
  input  wire logic signed [pft_pkg::FIELD_W-1:0] next_first_i,
  input  wire logic signed [pft_pkg::FIELD_W-1:0] next_second_i,
  input  wire logic [CountBits-1:0]               next_count_i,
  output logic                                    hit_o,
  output logic                                    valid_o,
  output logic signed [pft_pkg::FIELD_W-1:0]      first_o,
  output logic signed [pft_pkg::FIELD_W-1:0]      second_o,
  output logic [CountBits-1:0]                    count_o
);

  logic                               valid_q, valid_d;
  logic signed [pft_pkg::FIELD_W-1:0] first_q, first_d;
  logic signed [pft_pkg::FIELD_W-1:0] second_q, second_d;
  logic [CountBits-1:0]               count_q, count_d;
  logic                               claim;

  assign hit_o = valid_q && (first_q == pair_first_i) && (second_q == pair_second_i);
  assign claim = ctrl_i.take && !ctrl_i.any_hit && !valid_q && prev_valid_i;

  always_comb begin
    valid_d  = valid_q;
    first_d  = first_q;
    second_d = second_q;
    count_d  = count_q;
    if (ctrl_i.shift) begin
      valid_d  = next_valid_i;
      first_d  = next_first_i;
      second_d = next_second_i;
      count_d  = next_count_i;
    end else if (claim) begin
      valid_d  = 1'b1;
      first_d  = pair_first_i;
      second_d = pair_second_i;
      count_d  = {{(CountBits-1){1'b0}}, 1'b1};
    end else if (ctrl_i.take && hit_o && !(&count_q)) begin
      count_d = count_q + {{(CountBits-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    count_q  <= count_d;
  end

  assign valid_o  = valid_q;
  assign first_o  = first_q;
  assign second_o = second_q;
  assign count_o  = count_q;

endmodule

`default_nettype wire

>>> rtl/core/pair_frequency_table_core.sv
// One pair is accepted every cycle unless the input stalls. On the pair
// marked last, the state moves to readout, then the first entry is popped
// into the output register; further entries follow one per cycle while the
// output is not stalled, and the input stalls until the last one is popped.
// Reset clears the cell valid bits, the overflow flag and the output valid;
// no clearing pass is needed and the block accepts pairs right after reset.
// ----------------------------------------------------------------------------
// Pair frequency table core
// Row of entry cells that count distinct pairs in order of first appearance
// and shift out toward cell zero for the readout run.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_frequency_table_core #(
  parameter int TableDepth = pft_pkg::TABLE_DEPTH_DEF,
  parameter int CountBits  = pft_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [pft_pkg::FIELD_W-1:0]     pair_first_i,
  input  wire logic signed [pft_pkg::FIELD_W-1:0]     pair_second_i,
  input  wire logic                                   last_pair_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [pft_pkg::FIELD_W-1:0]          entry_first_o,
  output logic signed [pft_pkg::FIELD_W-1:0]          entry_second_o,
  output logic [pft_pkg::ENTRY_COUNT_W-1:0]           entry_count_o,
  output logic                                        table_overflowed_o,
  output logic                                        last_entry_o
);

  pft_pkg::state_e     state_q, state_d;
  pft_pkg::cell_ctrl_t ctrl;

  logic [TableDepth-1:0]              hit;
  logic [TableDepth-1:0]              valid;
  logic signed [pft_pkg::FIELD_W-1:0] first_a  [TableDepth];
  logic signed [pft_pkg::FIELD_W-1:0] second_a [TableDepth];
  logic [CountBits-1:0]               count_a  [TableDepth];

  logic take, pop, pop_last, any_hit;
  logic overflow_q, overflow_d;
  logic out_valid_q, out_valid_d;
  logic signed [pft_pkg::FIELD_W-1:0]  out_first_q, out_second_q;
  logic [pft_pkg::ENTRY_COUNT_W-1:0]   out_count_q;
  logic                                out_ovf_q, out_last_q;
  logic [CountBits+pft_pkg::ENTRY_COUNT_W-1:0] count_wide;

  assign in_stall_o = (state_q != pft_pkg::ST_COLLECT);
  assign take       = in_valid_i && !in_stall_o;
  assign any_hit    = |hit;
  assign pop        = (state_q == pft_pkg::ST_DRAIN) && valid[0] &&
                      (!out_valid_q || !out_stall_i);
  assign pop_last   = pop && !valid[1];

  assign ctrl.take    = take;
  assign ctrl.any_hit = any_hit;
  assign ctrl.shift   = pop;

  for (genvar k = 0; k < TableDepth; k++) begin : g_cell
    logic                               prev_valid;
    logic                               nxt_valid;
    logic signed [pft_pkg::FIELD_W-1:0] nxt_first, nxt_second;
    logic [CountBits-1:0]               nxt_count;

    if (k == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid[k-1];
    end

    if (k == TableDepth - 1) begin : g_tail
      assign nxt_valid  = 1'b0;
      assign nxt_first  = '0;
      assign nxt_second = '0;
      assign nxt_count  = '0;
    end else begin : g_link
      assign nxt_valid  = valid[k+1];
      assign nxt_first  = first_a[k+1];
      assign nxt_second = second_a[k+1];
      assign nxt_count  = count_a[k+1];
    end

    pft_cell #(
      .CountBits(CountBits)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .pair_first_i (pair_first_i),
      .pair_second_i(pair_second_i),
      .prev_valid_i (prev_valid),
      .next_valid_i (nxt_valid),
      .next_first_i (nxt_first),
      .next_second_i(nxt_second),
      .next_count_i (nxt_count),
      .hit_o        (hit[k]),
      .valid_o      (valid[k]),
      .first_o      (first_a[k]),
      .second_o     (second_a[k]),
      .count_o      (count_a[k])
    );
  end

  assign count_wide = {{pft_pkg::ENTRY_COUNT_W{1'b0}}, count_a[0]};

  always_comb begin
    state_d    = state_q;
    overflow_d = overflow_q;
    case (state_q)
      pft_pkg::ST_COLLECT: begin
        if (take && !any_hit && valid[TableDepth-1]) begin
          overflow_d = 1'b1;
        end
        if (take && last_pair_i) begin
          state_d = pft_pkg::ST_DRAIN;
        end
      end
      pft_pkg::ST_DRAIN: begin
        if (pop_last) begin
          state_d    = pft_pkg::ST_COLLECT;
          overflow_d = 1'b0;
        end
      end
      default: begin
        state_d    = pft_pkg::ST_COLLECT;
        overflow_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pft_pkg::ST_COLLECT;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_first_q  <= first_a[0];
      out_second_q <= second_a[0];
      out_count_q  <= count_wide[pft_pkg::ENTRY_COUNT_W-1:0];
      out_ovf_q    <= overflow_q;
      out_last_q   <= !valid[1];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign entry_first_o      = out_first_q;
  assign entry_second_o     = out_second_q;
  assign entry_count_o      = out_count_q;
  assign table_overflowed_o = out_ovf_q;
  assign last_entry_o       = out_last_q;

endmodule

`default_nettype wire

>>> rtl/core/pft_checker.sv
// ----------------------------------------------------------------------------
// Pair frequency table port checker
// Watches the ports of the table core for the ordering of the readout run
// against the input channel, its continuity, and stalled items holding still.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               last_pair_i,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic signed [pft_pkg::FIELD_W-1:0] entry_first_o,
  input wire logic signed [pft_pkg::FIELD_W-1:0] entry_second_o,
  input wire logic [pft_pkg::ENTRY_COUNT_W-1:0]  entry_count_o,
  input wire logic                               table_overflowed_o,
  input wire logic                               last_entry_o
);

  a_last_pair_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_pair_i) |=> in_stall_o)
    else $error("Input not stalled after the last pair of a set.");

  a_run_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_entry_o) |-> in_stall_o)
    else $error("Input accepted in the middle of a readout run.");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_entry_o) |=> out_valid_o)
    else $error("Readout run broke off before its last entry.");

  a_stalled_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(entry_first_o) &&
      $stable(entry_second_o) && $stable(entry_count_o) &&
      $stable(table_overflowed_o) && $stable(last_entry_o)))
    else $error("Stalled output item changed.");

endmodule

bind pair_frequency_table_core pft_checker u_pft_checker (.*);

`default_nettype wire
